FILE: hdl/ncst_pkg.sv
`timescale 1ns / 1ps
package ncst_pkg;
   localparam int NUM_SEMS_DEF   = 16;
   localparam int WAIT_DEPTH_DEF = 8;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_WAIT  = 2'd2,
      OP_POST  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_NOKEY  = 3'd2,
      ST_QFULL  = 3'd3,
      ST_BADIDX = 3'd4
   } status_type;

   typedef struct packed {
      op_type      opcode;
      logic [31:0] sem_key;
      logic [15:0] init_value;
      logic [3:0]  sem_index;
      logic [7:0]  requester_pid;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot_index;
      logic        granted;
      logic        woken_valid;
      logic [7:0]  woken_pid;
   } rsp_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_SCAN,
      EX_READ,
      EX_EXEC,
      EX_WAKE,
      EX_DONE
   } exec_state_type;
endpackage

FILE: hdl/ncst_fifo.sv
`timescale 1ns / 1ps
module ncst_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] data_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = data_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wp_in = ~wp_ff;
      end
      if (pop && !empty) begin
         rp_in = ~rp_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) begin
         data_ff[wp_ff] <= din;
      end
   end
endmodule

FILE: hdl/ncst_exec.sv
`timescale 1ns / 1ps
module ncst_exec #(
   parameter int NUM_SEMS   = ncst_pkg::NUM_SEMS_DEF,
   parameter int WAIT_DEPTH = ncst_pkg::WAIT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  ncst_pkg::req_type cmd,
   output logic              cmd_pop,
   input  logic              res_full,
   output logic              res_push,
   output ncst_pkg::rsp_type res
);
   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int LW = $clog2(WAIT_DEPTH + 1);

   ncst_pkg::exec_state_type state_ff, state_in;

   logic [NUM_SEMS-1:0] in_use_ff;
   logic [31:0]         key_mem  [NUM_SEMS];
   logic [15:0]         cnt_mem  [NUM_SEMS];
   logic [7:0]          refs_mem [NUM_SEMS];
   logic [QW-1:0]       head_mem [NUM_SEMS];
   logic [LW-1:0]       len_mem  [NUM_SEMS];
   logic [7:0]          pid_mem  [NUM_SEMS*WAIT_DEPTH];

   logic [SW:0]   scan_ff;
   logic          hit_ff, free_ok_ff;
   logic [SW-1:0] slot_ff;
   logic [15:0]   rcnt_ff;
   logic [7:0]    rrefs_ff, rpid_ff;
   logic [QW-1:0] rhead_ff;
   logic [LW-1:0] rlen_ff;
   ncst_pkg::rsp_type rsp_ff;

   logic [SW-1:0] sidx;
   logic [SW-1:0] widx;
   logic          idx_ok;
   logic          scan_hit;
   logic [QW:0]   tail_sum;
   logic [QW-1:0] tail;
   logic [QW-1:0] head_nx;

   assign sidx = scan_ff[SW-1:0];
   assign widx = SW'(cmd.sem_index);
   assign idx_ok = ({28'd0, cmd.sem_index} < 32'(NUM_SEMS)) && in_use_ff[widx];
   assign scan_hit = in_use_ff[sidx] && (key_mem[sidx] == cmd.sem_key);
   assign tail_sum = (QW+1)'(rhead_ff) + (QW+1)'(rlen_ff);
   assign tail = (tail_sum >= (QW+1)'(WAIT_DEPTH)) ?
                 QW'(tail_sum - (QW+1)'(WAIT_DEPTH)) : QW'(tail_sum);
   assign head_nx = (32'(rhead_ff) == 32'(WAIT_DEPTH - 1)) ? '0 : rhead_ff + QW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ncst_pkg::EX_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.opcode == ncst_pkg::OP_OPEN || cmd.opcode == ncst_pkg::OP_CLOSE) begin
                  state_in = ncst_pkg::EX_SCAN;
               end else if (idx_ok) begin
                  state_in = ncst_pkg::EX_READ;
               end else begin
                  state_in = ncst_pkg::EX_DONE;
               end
            end
         end
         ncst_pkg::EX_SCAN: begin
            if (scan_ff == (SW+1)'(NUM_SEMS - 1) || scan_hit) begin
               state_in = ncst_pkg::EX_READ;
            end
         end
         ncst_pkg::EX_READ: state_in = ncst_pkg::EX_EXEC;
         ncst_pkg::EX_EXEC: begin
            if (cmd.opcode == ncst_pkg::OP_POST && rlen_ff != '0) begin
               state_in = ncst_pkg::EX_WAKE;
            end else begin
               state_in = ncst_pkg::EX_DONE;
            end
         end
         ncst_pkg::EX_WAKE: state_in = ncst_pkg::EX_DONE;
         ncst_pkg::EX_DONE: begin
            if (!res_full) begin
               state_in = ncst_pkg::EX_IDLE;
            end
         end
         default: state_in = ncst_pkg::EX_IDLE;
      endcase
   end

   always_comb begin
      res_push = (state_ff == ncst_pkg::EX_DONE) && !res_full;
      cmd_pop  = res_push;
      res      = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ncst_pkg::EX_IDLE;
         in_use_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ncst_pkg::EX_EXEC) begin
            if (cmd.opcode == ncst_pkg::OP_OPEN && (hit_ff || free_ok_ff)) begin
               in_use_ff[slot_ff] <= 1'b1;
            end else if (cmd.opcode == ncst_pkg::OP_CLOSE && hit_ff && rrefs_ff <= 8'd1) begin
               in_use_ff[slot_ff] <= 1'b0;
            end
         end
      end

      rcnt_ff  <= cnt_mem[slot_ff];
      rrefs_ff <= refs_mem[slot_ff];
      rhead_ff <= head_mem[slot_ff];
      rlen_ff  <= len_mem[slot_ff];
      rpid_ff  <= pid_mem[(SW+QW)'(slot_ff) * (SW+QW)'(WAIT_DEPTH) + (SW+QW)'(rhead_ff)];

      unique case (state_ff)
         ncst_pkg::EX_IDLE: begin
            scan_ff    <= '0;
            hit_ff     <= 1'b0;
            free_ok_ff <= 1'b0;
            slot_ff    <= widx;
            rsp_ff     <= '{ncst_pkg::ST_BADIDX, 4'd0, 1'b0, 1'b0, 8'd0};
         end
         ncst_pkg::EX_SCAN: begin
            if (scan_hit) begin
               hit_ff  <= 1'b1;
               slot_ff <= sidx;
            end else begin
               if (!in_use_ff[sidx] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  slot_ff    <= sidx;
               end
               scan_ff <= scan_ff + (SW+1)'(1);
            end
         end
         ncst_pkg::EX_EXEC: begin
            unique case (cmd.opcode)
               ncst_pkg::OP_OPEN: begin
                  if (hit_ff) begin
                     if (rrefs_ff != 8'hFF) refs_mem[slot_ff] <= rrefs_ff + 8'd1;
                     rsp_ff.status     <= ncst_pkg::ST_OK;
                     rsp_ff.slot_index <= 4'(slot_ff);
                  end else if (free_ok_ff) begin
                     key_mem[slot_ff]  <= cmd.sem_key;
                     cnt_mem[slot_ff]  <= cmd.init_value;
                     refs_mem[slot_ff] <= 8'd1;
                     head_mem[slot_ff] <= '0;
                     len_mem[slot_ff]  <= '0;
                     rsp_ff.status     <= ncst_pkg::ST_OK;
                     rsp_ff.slot_index <= 4'(slot_ff);
                  end else begin
                     rsp_ff.status <= ncst_pkg::ST_FULL;
                  end
               end
               ncst_pkg::OP_CLOSE: begin
                  if (!hit_ff) begin
                     rsp_ff.status <= ncst_pkg::ST_NOKEY;
                  end else if (rrefs_ff <= 8'd1) begin
                     refs_mem[slot_ff] <= 8'd0;
                     rsp_ff.status     <= ncst_pkg::ST_OK;
                  end else begin
                     refs_mem[slot_ff] <= rrefs_ff - 8'd1;
                     rsp_ff.status     <= ncst_pkg::ST_OK;
                  end
               end
               ncst_pkg::OP_WAIT: begin
                  if (rcnt_ff != 16'd0) begin
                     cnt_mem[slot_ff] <= rcnt_ff - 16'd1;
                     rsp_ff.status    <= ncst_pkg::ST_OK;
                     rsp_ff.granted   <= 1'b1;
                  end else if (32'(rlen_ff) >= 32'(WAIT_DEPTH)) begin
                     rsp_ff.status <= ncst_pkg::ST_QFULL;
                  end else begin
                     pid_mem[(SW+QW)'(slot_ff) * (SW+QW)'(WAIT_DEPTH) + (SW+QW)'(tail)] <=
                        cmd.requester_pid;
                     len_mem[slot_ff] <= rlen_ff + LW'(1);
                     rsp_ff.status    <= ncst_pkg::ST_OK;
                  end
               end
               ncst_pkg::OP_POST: begin
                  rsp_ff.status <= ncst_pkg::ST_OK;
                  if (rlen_ff != '0) begin
                     head_mem[slot_ff] <= head_nx;
                     len_mem[slot_ff]  <= rlen_ff - LW'(1);
                  end else if (rcnt_ff != 16'hFFFF) begin
                     cnt_mem[slot_ff] <= rcnt_ff + 16'd1;
                  end
               end
               default: ;
            endcase
         end
         ncst_pkg::EX_WAKE: begin
            rsp_ff.woken_valid <= 1'b1;
            rsp_ff.woken_pid   <= rpid_ff;
         end
         default: ;
      endcase
   end
endmodule

FILE: hdl/named_counting_semaphore_table_core.sv
`timescale 1ns / 1ps
// Channel   Ports                              Handshake
// request   req_opcode .. req_requester_pid    push / full
// response  rsp_status .. rsp_woken_pid        empty / pop
//
// Open and close scan the slots for a key, one slot a cycle.
// Wait and post skip the scan and use the slot index; one item is worked on at a time.
// Reset is synchronous and frees every slot at once; no clearing pass.
// A full response queue stalls the back end; the request queue keeps taking items until it is full.
module named_counting_semaphore_table_core #(
   parameter int NUM_SEMS   = ncst_pkg::NUM_SEMS_DEF,
   parameter int WAIT_DEPTH = ncst_pkg::WAIT_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_sem_key,
   input  logic [15:0] req_init_value,
   input  logic [3:0]  req_sem_index,
   input  logic [7:0]  req_requester_pid,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_granted,
   output logic        rsp_woken_valid,
   output logic [7:0]  rsp_woken_pid
);
   ncst_pkg::req_type req_in, cmd;
   ncst_pkg::rsp_type res, rsp_out;
   logic cmd_empty, cmd_pop, res_full, res_push;

   assign req_in = '{ncst_pkg::op_type'(req_opcode), req_sem_key, req_init_value,
                     req_sem_index, req_requester_pid};

   ncst_fifo #(.WIDTH($bits(ncst_pkg::req_type))) u_req_q (
      .clock(clock), .reset(reset), .push(push), .full(full), .din(req_in),
      .pop(cmd_pop), .empty(cmd_empty), .dout(cmd));

   ncst_exec #(.NUM_SEMS(NUM_SEMS), .WAIT_DEPTH(WAIT_DEPTH)) u_exec (
      .clock(clock), .reset(reset), .cmd_empty(cmd_empty), .cmd(cmd), .cmd_pop(cmd_pop),
      .res_full(res_full), .res_push(res_push), .res(res));

   ncst_fifo #(.WIDTH($bits(ncst_pkg::rsp_type))) u_rsp_q (
      .clock(clock), .reset(reset), .push(res_push), .full(res_full), .din(res),
      .pop(pop), .empty(empty), .dout(rsp_out));

   assign rsp_status      = rsp_out.status;
   assign rsp_slot_index  = rsp_out.slot_index;
   assign rsp_granted     = rsp_out.granted;
   assign rsp_woken_valid = rsp_out.woken_valid;
   assign rsp_woken_pid   = rsp_out.woken_pid;
endmodule

FILE: verif/named_counting_semaphore_table_core_tb.sv
`timescale 1ns / 1ps
module named_counting_semaphore_table_core_tb;

   localparam int NSEM       = ncst_pkg::NUM_SEMS_DEF;
   localparam int QDEPTH     = ncst_pkg::WAIT_DEPTH_DEF;
   localparam int RAND_ITEMS = 1250;
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_opcode;
   logic [31:0] req_sem_key;
   logic [15:0] req_init_value;
   logic [3:0]  req_sem_index;
   logic [7:0]  req_requester_pid;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_index;
   logic        rsp_granted;
   logic        rsp_woken_valid;
   logic [7:0]  rsp_woken_pid;

   named_counting_semaphore_table_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_sem_key(req_sem_key),
      .req_init_value(req_init_value), .req_sem_index(req_sem_index),
      .req_requester_pid(req_requester_pid), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_slot_index(rsp_slot_index),
      .rsp_granted(rsp_granted), .rsp_woken_valid(rsp_woken_valid),
      .rsp_woken_pid(rsp_woken_pid)
   );

   // Shadow copy of the semaphore table.
   logic        sh_used [NSEM];
   logic [31:0] sh_key [NSEM];
   logic [15:0] sh_count [NSEM];
   logic [7:0]  sh_refs [NSEM];
   logic [7:0]  sh_pids [NSEM][QDEPTH];
   int          sh_head [NSEM];
   int          sh_len [NSEM];

   ncst_pkg::rsp_type pending_rsp [$];
   int      error_count;
   int      idle_cycles;
   bit      quiet_sender;
   bit      quiet_receiver;
   bit      hold_receiver;
   bit      stim_done;

   typedef struct {
      ncst_pkg::req_type req;
      bit                fixed;
      ncst_pkg::rsp_type rsp;
   } stim_row;

   stim_row stim_rows [$];

   function automatic ncst_pkg::rsp_type semaphore_step(ncst_pkg::req_type r);
      ncst_pkg::rsp_type o;
      int      s;
      int      pos;
      o = '0;
      o.status = ncst_pkg::ST_OK;
      s = -1;
      if (r.opcode == ncst_pkg::OP_OPEN || r.opcode == ncst_pkg::OP_CLOSE) begin
         for (int i = 0; i < NSEM; i++) begin
            if (s < 0 && sh_used[i] && sh_key[i] == r.sem_key) s = i;
         end
      end
      if (r.opcode == ncst_pkg::OP_OPEN) begin
         if (s < 0) begin
            for (int i = 0; i < NSEM; i++) begin
               if (s < 0 && !sh_used[i]) s = i;
            end
            if (s >= 0) begin
               sh_used[s] = 1'b1;
               sh_key[s] = r.sem_key;
               sh_count[s] = r.init_value;
               sh_refs[s] = '0;
               sh_head[s] = 0;
               sh_len[s] = 0;
            end
         end
         if (s < 0) begin
            o.status = ncst_pkg::ST_FULL;
         end else begin
            if (sh_refs[s] != 8'hFF) sh_refs[s]++;
            o.slot_index = 4'(s);
         end
      end else if (r.opcode == ncst_pkg::OP_CLOSE) begin
         if (s < 0) begin
            o.status = ncst_pkg::ST_NOKEY;
         end else if (sh_refs[s] <= 8'd1) begin
            sh_refs[s] = '0;
            sh_used[s] = 1'b0;
         end else begin
            sh_refs[s]--;
         end
      end else if (int'(r.sem_index) >= NSEM || !sh_used[r.sem_index]) begin
         o.status = ncst_pkg::ST_BADIDX;
      end else if (r.opcode == ncst_pkg::OP_WAIT) begin
         s = int'(r.sem_index);
         if (sh_count[s] != 16'd0) begin
            sh_count[s]--;
            o.granted = 1'b1;
         end else if (sh_len[s] >= QDEPTH) begin
            o.status = ncst_pkg::ST_QFULL;
         end else begin
            pos = (sh_head[s] + sh_len[s]) % QDEPTH;
            sh_pids[s][pos] = r.requester_pid;
            sh_len[s]++;
         end
      end else begin
         s = int'(r.sem_index);
         if (sh_len[s] > 0) begin
            o.woken_valid = 1'b1;
            o.woken_pid = sh_pids[s][sh_head[s]];
            sh_head[s] = (sh_head[s] + 1) % QDEPTH;
            sh_len[s]--;
         end else if (sh_count[s] != 16'hFFFF) begin
            sh_count[s]++;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic ncst_pkg::req_type make_req(ncst_pkg::op_type op, logic [31:0] key,
                                                  logic [15:0] init, logic [3:0] idx,
                                                  logic [7:0] pid);
      ncst_pkg::req_type r;
      r.opcode = op;
      r.sem_key = key;
      r.init_value = init;
      r.sem_index = idx;
      r.requester_pid = pid;
      return r;
   endfunction

   function automatic ncst_pkg::rsp_type make_rsp(ncst_pkg::status_type st, logic [3:0] slot,
                                                  logic g, logic wv, logic [7:0] wp);
      ncst_pkg::rsp_type o;
      o.status = st;
      o.slot_index = slot;
      o.granted = g;
      o.woken_valid = wv;
      o.woken_pid = wp;
      return o;
   endfunction

   task automatic add_row(ncst_pkg::req_type r, bit fixed, ncst_pkg::rsp_type o);
      stim_row row;
      row.req = r;
      row.fixed = fixed;
      row.rsp = o;
      stim_rows.push_back(row);
   endtask

   function automatic ncst_pkg::req_type random_req(int key_pool);
      ncst_pkg::req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.opcode = pick < 20 ? ncst_pkg::OP_OPEN :
                 pick < 32 ? ncst_pkg::OP_CLOSE :
                 pick < 66 ? ncst_pkg::OP_WAIT : ncst_pkg::OP_POST;
      r.sem_key = ($urandom_range(0, 9) == 0) ? $urandom() :
                  32'h5A00_0000 + 32'($urandom_range(0, key_pool));
      r.init_value = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                     16'($urandom_range(0, 3));
      r.sem_index = ($urandom_range(0, 3) == 0) ? 4'($urandom()) :
                    4'($urandom_range(0, 5));
      r.requester_pid = 8'($urandom());
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
      hold_receiver = 1'b0;
      @(negedge reset);
      repeat (3000) @(posedge clock);
      quiet_sender <= 1'b1;
      quiet_receiver <= 1'b1;
      repeat (2500) @(posedge clock);
      quiet_sender <= 1'b0;
      quiet_receiver <= 1'b0;
      repeat (2000) @(posedge clock);
      hold_receiver <= 1'b1;
      repeat (400) @(posedge clock);
      hold_receiver <= 1'b0;
   end

   // Sender.
   initial begin
      stim_row row;
      int      n;
      for (int i = 0; i < NSEM; i++) begin
         sh_used[i] = 1'b0;
         sh_len[i] = 0;
         sh_head[i] = 0;
      end
      error_count = 0;
      stim_done = 1'b0;
      push = 1'b0;
      req_opcode = '0;
      req_sem_key = '0;
      req_init_value = '0;
      req_sem_index = '0;
      req_requester_pid = '0;

      add_row(make_req(ncst_pkg::OP_WAIT, 32'h0, 16'h0, 4'd0, 8'h00), 1'b1,
              make_rsp(ncst_pkg::ST_BADIDX, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_POST, 32'h0, 16'h0, 4'd15, 8'hFF), 1'b1,
              make_rsp(ncst_pkg::ST_BADIDX, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_CLOSE, 32'hFFFF_FFFF, 16'h0, 4'd0, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_NOKEY, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_OPEN, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_POST, 32'h0, 16'h0, 4'd0, 8'h0), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_WAIT, 32'h0, 16'h0, 4'd0, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_OK, 4'd0, 1'b1, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_OPEN, 32'h0, 16'h0, 4'd0, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_OK, 4'd1, 1'b0, 1'b0, 8'd0));
      for (int i = 0; i < QDEPTH; i++)
         add_row(make_req(ncst_pkg::OP_WAIT, 32'h0, 16'h0, 4'd1, 8'(8'hF0 + i)), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_WAIT, 32'h0, 16'h0, 4'd1, 8'hAA), 1'b1,
              make_rsp(ncst_pkg::ST_QFULL, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_POST, 32'h0, 16'h0, 4'd1, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_OK, 4'd0, 1'b0, 1'b1, 8'hF0));
      add_row(make_req(ncst_pkg::OP_OPEN, 32'h0, 16'h5, 4'd0, 8'h0), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_CLOSE, 32'h0, 16'h0, 4'd0, 8'h0), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_CLOSE, 32'h0, 16'h0, 4'd0, 8'h0), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_WAIT, 32'h0, 16'h0, 4'd1, 8'h0), 1'b1,
              make_rsp(ncst_pkg::ST_BADIDX, 4'd0, 1'b0, 1'b0, 8'd0));
      add_row(make_req(ncst_pkg::OP_OPEN, 32'h0, 16'h0, 4'd0, 8'h0), 1'b0, '0);
      add_row(make_req(ncst_pkg::OP_POST, 32'h0, 16'h0, 4'd1, 8'h0), 1'b0, '0);

      n = stim_rows.size() + RAND_ITEMS;
      for (int i = 0; i < n; i++) begin
         if (stim_rows.size() != 0) begin
            row = stim_rows.pop_front();
         end else begin
            row.fixed = 1'b0;
            // Fill the table now and then so that it runs out of slots.
            row.req = random_req(i % 200 < 40 ? 40 : 8);
            if (i % 300 < 30) row.req.opcode = ncst_pkg::OP_OPEN;
            if (i % 300 >= 30 && i % 300 < 60 && row.req.opcode == ncst_pkg::OP_OPEN)
               row.req.opcode = ncst_pkg::OP_CLOSE;
         end
         if (!quiet_sender && $urandom_range(0, 99) < 36) begin
            push <= 1'b0;
            do @(posedge clock); while (!quiet_sender && $urandom_range(0, 99) < 36);
         end
         push <= 1'b1;
         req_opcode <= row.req.opcode;
         req_sem_key <= row.req.sem_key;
         req_init_value <= row.req.init_value;
         req_sem_index <= row.req.sem_index;
         req_requester_pid <= row.req.requester_pid;
         do @(posedge clock); while (reset || full);
         if (row.fixed) begin
            pending_rsp.push_back(row.rsp);
            void'(semaphore_step(row.req));
         end else begin
            pending_rsp.push_back(semaphore_step(row.req));
         end
      end
      push <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver.
   initial begin
      ncst_pkg::rsp_type want;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (pop && !empty && !reset) begin
            if (pending_rsp.size() == 0) begin
               $display("unexpected response item");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_slot_index != want.slot_index)
                  report_mismatch("slot_index", int'(rsp_slot_index), int'(want.slot_index));
               if (rsp_granted != want.granted)
                  report_mismatch("granted", int'(rsp_granted), int'(want.granted));
               if (rsp_woken_valid != want.woken_valid)
                  report_mismatch("woken_valid", int'(rsp_woken_valid),
                                  int'(want.woken_valid));
               if (rsp_woken_pid != want.woken_pid)
                  report_mismatch("woken_pid", int'(rsp_woken_pid), int'(want.woken_pid));
            end
         end
         pop <= !hold_receiver && (quiet_receiver || $urandom_range(0, 99) >= 36);
      end
   end

   // Watchdog and end of run.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("named_counting_semaphore_table_core_tb: errors");
            $finish;
         end
         if (stim_done && pending_rsp.size() == 0) begin
            repeat (40) @(posedge clock);
            if (error_count == 0 && empty) begin
               $display("named_counting_semaphore_table_core_tb: clean");
            end else begin
               if (!empty) $display("unexpected response item left at end");
               $display("named_counting_semaphore_table_core_tb: errors");
            end
            $finish;
         end
      end
   end
endmodule
